>>> hw/rtl/cqwl_pkg.sv
// Package for the circular queue with listing.
// Holds the queue depth, operation and status codes, control structs and slot helpers.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package cqwl_pkg;

    localparam int DEPTH = 8;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W = 32;
    localparam int SLOT_W = 3;

    localparam logic [1:0] MODE_LIST = 2'd0;
    localparam logic [1:0] MODE_ENQ  = 2'd1;
    localparam logic [1:0] MODE_DEQ  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef logic [PTR_W-1:0] t_ptr;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch the request fields
        logic exec;       // carry out the captured request
        logic list_load;  // start a listing walk at the head
        logic list_step;  // emit one listed entry and advance
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] mode;
        logic       empty;
        logic       list_fin;
    } t_stat;

    function automatic t_ptr next_slot(input t_ptr s);
        return (s == t_ptr'(DEPTH - 1)) ? '0 : t_ptr'(s + 1'b1);
    endfunction

    // Low bits of a slot pointer, zero-extended when the pointer is narrow.
    function automatic logic [SLOT_W-1:0] to_slot(input t_ptr s);
        logic [PTR_W+SLOT_W-1:0] e;
        e = {{SLOT_W{1'b0}}, s};
        return e[SLOT_W-1:0];
    endfunction

endpackage

>>> hw/rtl/cqwl_ctrl.sv
// Controller state machine of the circular queue with listing.
// Sequences capture, execution and the listing walk; depends on cqwl_pkg.
`timescale 1ns / 1ps

module cqwl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  cqwl_pkg::t_stat i_stat,
    output cqwl_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.mode == cqwl_pkg::MODE_LIST && !i_stat.empty) begin
                    o_cmd.list_load = 1'b1;
                    n_state         = S_LIST;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                o_cmd.list_step = 1'b1;
                if (i_stat.list_fin) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

>>> hw/rtl/cqwl_dp.sv
// Datapath of the circular queue with listing: entry memory, head and tail
// pointers, empty flag, listing pointer and result registers. Depends on cqwl_pkg.
`timescale 1ns / 1ps

module cqwl_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [1:0]                           i_mode,
    input  logic signed [cqwl_pkg::WORD_W-1:0]   i_push_value,
    input  cqwl_pkg::t_cmd                       i_cmd,
    output cqwl_pkg::t_stat                      o_stat,
    output logic                                 o_strobe,
    output logic [1:0]                           o_status,
    output logic signed [cqwl_pkg::WORD_W-1:0]   o_value,
    output logic [cqwl_pkg::SLOT_W-1:0]          o_slot_index,
    output logic                                 o_last
);

    logic [cqwl_pkg::WORD_W-1:0] mem [cqwl_pkg::DEPTH];

    logic [1:0]                  r_mode;
    logic [cqwl_pkg::WORD_W-1:0] r_word;
    cqwl_pkg::t_ptr              r_head;
    cqwl_pkg::t_ptr              r_tail;
    logic                        r_empty;
    cqwl_pkg::t_ptr              r_ptr;
    logic [cqwl_pkg::WORD_W-1:0] r_rd_data;

    logic                        r_strobe;
    logic [1:0]                  r_status;
    logic [cqwl_pkg::WORD_W-1:0] r_value;
    logic [cqwl_pkg::SLOT_W-1:0] r_slot;
    logic                        r_last;

    cqwl_pkg::t_ptr              tail_next;
    cqwl_pkg::t_ptr              rd_addr;
    logic                        full;
    logic                        wr_en;
    cqwl_pkg::t_ptr              wr_addr;

    assign tail_next = cqwl_pkg::next_slot(r_tail);
    assign full      = !r_empty && (tail_next == r_head);
    assign rd_addr   = i_cmd.list_step ? cqwl_pkg::next_slot(r_ptr) : r_head;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = tail_next;
        if (i_cmd.exec && r_mode == cqwl_pkg::MODE_ENQ) begin
            if (r_empty) begin
                wr_en   = 1'b1;
                wr_addr = '0;
            end else if (!full) begin
                wr_en = 1'b1;
            end
        end
    end

    // The read port is registered; the head entry is ready in the cycle after
    // the request is taken, and each listing step prefetches the next slot.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_word;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_word <= i_push_value;
        end
        if (i_cmd.list_load) begin
            r_ptr <= r_head;
        end else if (i_cmd.list_step) begin
            r_ptr <= cqwl_pkg::next_slot(r_ptr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_empty  <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cmd.exec) begin
                case (r_mode)
                    cqwl_pkg::MODE_ENQ: begin
                        r_strobe <= 1'b1;
                        r_last   <= 1'b1;
                        if (r_empty) begin
                            r_head   <= '0;
                            r_tail   <= '0;
                            r_empty  <= 1'b0;
                            r_status <= cqwl_pkg::ST_OK;
                            r_value  <= r_word;
                            r_slot   <= '0;
                        end else if (full) begin
                            r_status <= cqwl_pkg::ST_OVERFLOW;
                            r_value  <= '0;
                            r_slot   <= '0;
                        end else begin
                            r_tail   <= tail_next;
                            r_status <= cqwl_pkg::ST_OK;
                            r_value  <= r_word;
                            r_slot   <= cqwl_pkg::to_slot(tail_next);
                        end
                    end
                    cqwl_pkg::MODE_DEQ: begin
                        r_strobe <= 1'b1;
                        r_last   <= 1'b1;
                        if (r_empty) begin
                            r_status <= cqwl_pkg::ST_UNDERFLOW;
                            r_value  <= '0;
                            r_slot   <= '0;
                        end else begin
                            r_status <= cqwl_pkg::ST_OK;
                            r_value  <= r_rd_data;
                            r_slot   <= cqwl_pkg::to_slot(r_head);
                            if (r_head == r_tail) begin
                                r_head  <= '0;
                                r_tail  <= '0;
                                r_empty <= 1'b1;
                            end else begin
                                r_head <= cqwl_pkg::next_slot(r_head);
                            end
                        end
                    end
                    cqwl_pkg::MODE_LIST: begin
                        // A non-empty queue is walked in the listing state.
                        if (r_empty) begin
                            r_strobe <= 1'b1;
                            r_last   <= 1'b1;
                            r_status <= cqwl_pkg::ST_EMPTY;
                            r_value  <= '0;
                            r_slot   <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (i_cmd.list_step) begin
                r_strobe <= 1'b1;
                r_status <= cqwl_pkg::ST_OK;
                r_value  <= r_rd_data;
                r_slot   <= cqwl_pkg::to_slot(r_ptr);
                r_last   <= (r_ptr == r_tail);
            end
        end
    end

    assign o_stat.mode     = r_mode;
    assign o_stat.empty    = r_empty;
    assign o_stat.list_fin = (r_ptr == r_tail);

    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_value      = $signed(r_value);
    assign o_slot_index = r_slot;
    assign o_last       = r_last;

endmodule

>>> hw/rtl/circular_queue_with_listing.sv
// Circular queue of signed 32-bit words with enqueue, dequeue and listing.
// Enqueue and dequeue: result strobed after the execute state; busy for one cycle.
// List: first result follows the execute state and first listing step, then one per stored
// entry on consecutive cycles, paced by the single registered read port of the memory.
// Synchronous active-low reset empties the queue; entry contents are not cleared.
// Results are shown for one cycle on o_strobe and cannot be stalled.
`timescale 1ns / 1ps

module circular_queue_with_listing (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_mode,
    input  logic signed [cqwl_pkg::WORD_W-1:0] i_push_value,
    output logic                               o_strobe,
    output logic [1:0]                         o_status,
    output logic signed [cqwl_pkg::WORD_W-1:0] o_value,
    output logic [cqwl_pkg::SLOT_W-1:0]        o_slot_index,
    output logic                               o_last
);

    cqwl_pkg::t_cmd  cmd;
    cqwl_pkg::t_stat stat;

    cqwl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    cqwl_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_value      (o_value),
        .o_slot_index (o_slot_index),
        .o_last       (o_last)
    );

endmodule

>>> hw/rtl/cqwl_chk.sv
// Port-level checker for the circular queue with listing, bound to the top level.
// Depends on cqwl_pkg for the status codes.
`timescale 1ns / 1ps

module cqwl_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_strobe,
    input logic [1:0]                         o_status,
    input logic signed [cqwl_pkg::WORD_W-1:0] o_value,
    input logic [cqwl_pkg::SLOT_W-1:0]        o_slot_index,
    input logic                               o_last
);

    // A taken request keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy next cycle");

    // Error results carry zero data and close the request.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != cqwl_pkg::ST_OK) |->
        (o_last && o_value == '0 && o_slot_index == '0))
        else $error("error result with nonzero data or without last");

    // A listing runs without gaps until its final entry.
    a_list_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("gap in listing results");

    // The block is free exactly when the final result of a request is shown.
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (busy == !o_last))
        else $error("busy does not match the last flag of a result");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !busy))
        else $error("result or busy right after reset");

endmodule

bind circular_queue_with_listing cqwl_chk u_chk (.*);

>>> test/circular_queue_with_listing_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the circular queue with listing.
// Keeps a shadow copy of the queue in a small class and checks each strobed result in order.
// Depends on cqwl_pkg and the circular_queue_with_listing RTL.

typedef struct {
    logic [1:0]                         status;
    logic signed [cqwl_pkg::WORD_W-1:0] value;
    logic [cqwl_pkg::SLOT_W-1:0]        slot;
    logic                               last;
} t_queue_result;

class t_queue_shadow;
    logic signed [cqwl_pkg::WORD_W-1:0] words [cqwl_pkg::DEPTH];
    cqwl_pkg::t_ptr                     head;
    cqwl_pkg::t_ptr                     tail;
    bit                                 empty;
    t_queue_result                      awaited [$];
    int                                 mismatches;

    function new();
        head = '0;
        tail = '0;
        empty = 1'b1;
        mismatches = 0;
    endfunction

    function cqwl_pkg::t_ptr advance(input cqwl_pkg::t_ptr s);
        int n;
        n = int'(s) + 1;
        return (n >= cqwl_pkg::DEPTH) ? '0 : cqwl_pkg::t_ptr'(n);
    endfunction

    // The slot port carries only the low bits of the slot.
    function logic [cqwl_pkg::SLOT_W-1:0] slot_of(input cqwl_pkg::t_ptr s);
        logic [31:0] w;
        w = 32'(s);
        return w[cqwl_pkg::SLOT_W-1:0];
    endfunction

    function void await_result(input logic [1:0] status,
                               input logic signed [cqwl_pkg::WORD_W-1:0] value,
                               input logic [cqwl_pkg::SLOT_W-1:0] slot, input logic last);
        t_queue_result r;
        r.status = status;
        r.value = value;
        r.slot = slot;
        r.last = last;
        awaited.push_back(r);
    endfunction

    // Updates the shadow queue for one accepted request and queues its results.
    function void apply_request(input logic [1:0] mode,
                                input logic signed [cqwl_pkg::WORD_W-1:0] word);
        cqwl_pkg::t_ptr s;
        case (mode)
            cqwl_pkg::MODE_ENQ: begin
                if (empty) begin
                    head = '0;
                    tail = '0;
                    words[0] = word;
                    empty = 1'b0;
                    await_result(cqwl_pkg::ST_OK, word, '0, 1'b1);
                end else if (advance(tail) == head) begin
                    await_result(cqwl_pkg::ST_OVERFLOW, '0, '0, 1'b1);
                end else begin
                    tail = advance(tail);
                    words[tail] = word;
                    await_result(cqwl_pkg::ST_OK, word, slot_of(tail), 1'b1);
                end
            end
            cqwl_pkg::MODE_DEQ: begin
                if (empty) begin
                    await_result(cqwl_pkg::ST_UNDERFLOW, '0, '0, 1'b1);
                end else begin
                    await_result(cqwl_pkg::ST_OK, words[head], slot_of(head), 1'b1);
                    if (head == tail) begin
                        head = '0;
                        tail = '0;
                        empty = 1'b1;
                    end else begin
                        head = advance(head);
                    end
                end
            end
            cqwl_pkg::MODE_LIST: begin
                if (empty) begin
                    await_result(cqwl_pkg::ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    s = head;
                    for (int n = 0; n < cqwl_pkg::DEPTH; n++) begin
                        await_result(cqwl_pkg::ST_OK, words[s], slot_of(s), s == tail);
                        if (s == tail) break;
                        s = advance(s);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function void compare_result(input logic [1:0] status,
                                 input logic signed [cqwl_pkg::WORD_W-1:0] value,
                                 input logic [cqwl_pkg::SLOT_W-1:0] slot, input logic last);
        t_queue_result want;
        if (awaited.size() == 0) begin
            $display("%0t: unexpected result: status %0d value %0d slot %0d last %0d",
                     $time, status, value, slot, last);
            mismatches++;
            return;
        end
        want = awaited.pop_front();
        if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            mismatches++;
        end
        if (value !== want.value) begin
            $display("%0t: value expected %0d actual %0d", $time, want.value, value);
            mismatches++;
        end
        if (slot !== want.slot) begin
            $display("%0t: slot_index expected %0d actual %0d", $time, want.slot, slot);
            mismatches++;
        end
        if (last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, last);
            mismatches++;
        end
    endfunction
endclass

module circular_queue_with_listing_tb;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 24;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    logic [1:0]                          i_mode;
    logic signed [cqwl_pkg::WORD_W-1:0]  i_push_value;
    logic                                o_strobe;
    logic [1:0]                          o_status;
    logic signed [cqwl_pkg::WORD_W-1:0]  o_value;
    logic [cqwl_pkg::SLOT_W-1:0]         o_slot_index;
    logic                                o_last;

    t_queue_shadow shadow;
    int            cycle_count = 0;

    circular_queue_with_listing dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_value      (o_value),
        .o_slot_index (o_slot_index),
        .o_last       (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Results are checked before the request taken at the same edge is applied.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                shadow.compare_result(o_status, o_value, o_slot_index, o_last);
            if (start && !busy)
                shadow.apply_request(i_mode, i_push_value);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Holds one request on the ports until the block takes it.
    task automatic issue(input logic [1:0] mode,
                         input logic signed [cqwl_pkg::WORD_W-1:0] word);
        start <= 1'b1;
        i_mode <= mode;
        i_push_value <= word;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // With the given chance, drops start for a random pause with junk on the fields.
    task automatic pause_sender(input int pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            i_mode <= 2'($urandom);
            i_push_value <= $urandom;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic logic [1:0] pick_mode(input int enq_pct);
        int r;
        r = $urandom_range(99);
        if (r < 3) return MODE_UNUSED;
        if (r < 18) return cqwl_pkg::MODE_LIST;
        return ($urandom_range(99) < enq_pct) ? cqwl_pkg::MODE_ENQ : cqwl_pkg::MODE_DEQ;
    endfunction

    function automatic logic signed [cqwl_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(15))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int idle_pct [5] = '{0, 59, 25, 59, 0};
        int enq_pct;
        shadow = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        i_mode = cqwl_pkg::MODE_LIST;
        i_push_value = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(cqwl_pkg::MODE_LIST, '0);
        issue(cqwl_pkg::MODE_DEQ, '0);
        issue(MODE_UNUSED, 32'sh7fff_ffff);
        issue(cqwl_pkg::MODE_ENQ, 32'sh8000_0000);
        issue(cqwl_pkg::MODE_ENQ, 32'sh7fff_ffff);
        issue(cqwl_pkg::MODE_ENQ, '0);
        issue(cqwl_pkg::MODE_ENQ, -32'sd1);
        issue(cqwl_pkg::MODE_ENQ, 32'sh5555_5555);
        issue(cqwl_pkg::MODE_ENQ, 32'shaaaa_aaaa);
        issue(cqwl_pkg::MODE_ENQ, 32'sd1);
        issue(cqwl_pkg::MODE_ENQ, -32'sd2);
        issue(cqwl_pkg::MODE_ENQ, 32'sh1234_5678);
        issue(cqwl_pkg::MODE_LIST, '0);
        issue(cqwl_pkg::MODE_DEQ, '0);
        // The tail wraps around to slot zero here.
        issue(cqwl_pkg::MODE_ENQ, 32'sh1357_9bdf);
        issue(cqwl_pkg::MODE_LIST, '0);
        repeat (8) issue(cqwl_pkg::MODE_DEQ, '0);
        issue(cqwl_pkg::MODE_LIST, '0);

        // The enqueue share drifts so the fill level sweeps between empty and full.
        for (int ph = 0; ph < 5; ph++) begin
            for (int k = 0; k < 60; k++) begin
                if (k % 15 == 0) enq_pct = $urandom_range(15, 85);
                pause_sender(idle_pct[ph]);
                issue(pick_mode(enq_pct), pick_word());
            end
        end
        start <= 1'b0;

        while (shadow.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
